### sv/lru_lookup_cost_counter_assert.svh
// Assertion macros for the LRU lookup cost counter checker.
// No dependencies; included by the checker file only.
`ifndef LRU_LOOKUP_COST_COUNTER_ASSERT_SVH
`define LRU_LOOKUP_COST_COUNTER_ASSERT_SVH

// Next-cycle implication, disabled while reset is asserted.
`define LCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// Same-cycle implication, disabled while reset is asserted.
`define LCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

`endif

### sv/lru_lcc_pkg.sv
// Shared constants, types and the case-fold function for the LRU lookup block.
// No dependencies; used by the cell row, the top level and the checker.
package lru_lcc_pkg;

    localparam int unsigned KEY_W      = 64;
    localparam int unsigned SLOT_W     = 5;
    localparam int unsigned TOTAL_W    = 32;
    localparam int unsigned SIZE_W     = 6;
    localparam int unsigned COST_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned DEF_WAYS   = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_COST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_COST  = 2'd2;

    // Register reset values
    localparam logic [SIZE_W-1:0] RST_CACHE_SIZE = 6'd0;
    localparam logic [COST_W-1:0] RST_HIT_COST   = 8'd1;
    localparam logic [COST_W-1:0] RST_MISS_COST  = 8'd5;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic             clear;   // drop all entries (start of run)
        logic             update;  // apply lookup result this cycle
        logic             hit;     // lookup hit: touch the matching entry
        logic             fill;    // miss with room: fill the free entry
        logic [KEY_W-1:0] key;     // folded key
    } t_cell_cmd;

    // Fold 'A'..'Z' to lower case in each of the eight bytes
    function automatic logic [KEY_W-1:0] fold_case(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic [7:0]       b;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            b = k[8*i +: 8];
            if (b >= 8'h41 && b <= 8'h5A) begin
                b = b + 8'h20;
            end
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

endpackage

### sv/lru_lookup_cost_counter.sv
// Taking a request on start raises busy; o_done is registered from busy and rises
// in the cycle after busy. No new request is taken while busy; busy covers the single
// cycle in which the cell row compares the key and updates tags and recency ranks.
// Results show for one cycle on o_done; the receiver cannot stall.
// Reset (i_rst_n, synchronous): entries invalid, total zero, registers to defaults, idle.
module lru_lookup_cost_counter #(
    parameter int unsigned WAYS = lru_lcc_pkg::DEF_WAYS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // request channel
    input  logic                                   start,
    output logic                                   busy,
    input  logic [lru_lcc_pkg::KEY_W-1:0]          i_key,
    input  logic                                   i_first_of_run,
    // result channel
    output logic                                   o_done,
    output logic                                   o_hit,
    output logic [lru_lcc_pkg::SLOT_W-1:0]         o_slot,
    output logic [lru_lcc_pkg::TOTAL_W-1:0]        o_total_cost,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [lru_lcc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lru_lcc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int unsigned IW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned CW = $clog2(WAYS + 1);
    localparam int unsigned TW = lru_lcc_pkg::TOTAL_W;

    // Configuration registers
    logic [lru_lcc_pkg::SIZE_W-1:0] r_cache_size;
    logic [lru_lcc_pkg::COST_W-1:0] r_hit_cost;
    logic [lru_lcc_pkg::COST_W-1:0] r_miss_cost;

    // Control and accounting
    logic                          r_busy;
    logic [lru_lcc_pkg::KEY_W-1:0] r_key;
    logic [CW-1:0]                 r_used;
    logic [TW-1:0]                 r_total;
    logic [TW-1:0]                 n_total;
    logic [CW-1:0]                 n_used;

    // Result registers
    logic                            r_done;
    logic                            r_hit;
    logic [lru_lcc_pkg::SLOT_W-1:0]  r_slot;

    logic                   accept;
    logic [CW-1:0]          size_eff;
    logic                   size_zero;
    logic                   room;
    logic [IW-1:0]          fill_idx;
    logic [IW-1:0]          lru_rank;
    logic [IW-1:0]          slot_sel;
    logic                   hit_now;
    logic [lru_lcc_pkg::COST_W-1:0] cost;
    logic [TW:0]            sum;
    lru_lcc_pkg::t_cell_cmd cmd;

    // Lookup chain through the cell row
    logic          w_hit      [0:WAYS];
    logic [IW-1:0] w_hit_slot [0:WAYS];
    logic [IW-1:0] w_hit_rank [0:WAYS];
    logic [IW-1:0] w_lru_slot [0:WAYS];

    assign accept = start && !r_busy;

    // Configuration writes; indexes past the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_size <= lru_lcc_pkg::RST_CACHE_SIZE;
            r_hit_cost   <= lru_lcc_pkg::RST_HIT_COST;
            r_miss_cost  <= lru_lcc_pkg::RST_MISS_COST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lru_lcc_pkg::CFG_CACHE_SIZE:
                    r_cache_size <= i_cfg_wdata[lru_lcc_pkg::SIZE_W-1:0];
                lru_lcc_pkg::CFG_HIT_COST:  r_hit_cost  <= i_cfg_wdata;
                lru_lcc_pkg::CFG_MISS_COST: r_miss_cost <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective size and miss handling selection
    always_comb begin
        if (32'(r_cache_size) < WAYS) begin
            size_eff = CW'(r_cache_size);
        end else begin
            size_eff = CW'(WAYS);
        end
        size_zero = (size_eff == '0);
        room      = (r_used < size_eff);
        fill_idx  = r_used[IW-1:0];
        lru_rank  = IW'(r_used - 1'b1);
        hit_now   = !size_zero && w_hit[WAYS];
    end

    // Command to the cells
    always_comb begin
        cmd.clear  = accept && i_first_of_run;
        cmd.update = r_busy && !size_zero;
        cmd.hit    = w_hit[WAYS];
        cmd.fill   = room;
        cmd.key    = r_key;
    end

    assign w_hit[0]      = 1'b0;
    assign w_hit_slot[0] = '0;
    assign w_hit_rank[0] = '0;
    assign w_lru_slot[0] = '0;

    for (genvar g = 0; g < WAYS; g++) begin : g_cell
        lru_lcc_cell #(
            .WAYS (WAYS),
            .IDX  (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_limit       (w_hit_rank[WAYS]),
            .i_lru_rank    (lru_rank),
            .i_fill_idx    (fill_idx),
            .i_hit_in      (w_hit[g]),
            .i_hit_slot_in (w_hit_slot[g]),
            .i_hit_rank_in (w_hit_rank[g]),
            .i_lru_slot_in (w_lru_slot[g]),
            .o_hit         (w_hit[g+1]),
            .o_hit_slot    (w_hit_slot[g+1]),
            .o_hit_rank    (w_hit_rank[g+1]),
            .o_lru_slot    (w_lru_slot[g+1])
        );
    end

    // Slot, count and saturating total for the request in flight
    always_comb begin
        if (size_zero) begin
            slot_sel = '0;
        end else if (w_hit[WAYS]) begin
            slot_sel = w_hit_slot[WAYS];
        end else if (room) begin
            slot_sel = fill_idx;
        end else begin
            slot_sel = w_lru_slot[WAYS];
        end
        n_used = r_used;
        if (!size_zero && !w_hit[WAYS] && room) begin
            n_used = r_used + 1'b1;
        end
        cost    = hit_now ? r_hit_cost : r_miss_cost;
        sum     = {1'b0, r_total} + (TW + 1)'(cost);
        n_total = sum[TW] ? '1 : sum[TW-1:0];
    end

    // Request tracking and accounting state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_used  <= '0;
            r_total <= '0;
        end else begin
            r_done <= r_busy;
            if (accept) begin
                r_busy <= 1'b1;
                if (i_first_of_run) begin
                    r_used  <= '0;
                    r_total <= '0;
                end
            end else if (r_busy) begin
                r_busy  <= 1'b0;
                r_used  <= n_used;
                r_total <= n_total;
            end
        end
    end

    // Key capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= lru_lcc_pkg::fold_case(i_key);
        end
        if (r_busy) begin
            r_hit  <= hit_now;
            r_slot <= lru_lcc_pkg::SLOT_W'(slot_sel);
        end
    end

    assign busy         = r_busy;
    assign o_done       = r_done;
    assign o_hit        = r_hit;
    assign o_slot       = r_slot;
    assign o_total_cost = r_total;

endmodule

### sv/lru_lcc_cell.sv
// One entry of the tag store: tag, valid bit and recency rank.
// Depends on lru_lcc_pkg; instantiated as a row by lru_lookup_cost_counter.
module lru_lcc_cell #(
    parameter int unsigned WAYS = lru_lcc_pkg::DEF_WAYS,
    parameter int unsigned IDX  = 0
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  lru_lcc_pkg::t_cell_cmd                    i_cmd,
    input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] i_limit,
    input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] i_lru_rank,
    input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] i_fill_idx,
    input  logic                                      i_hit_in,
    input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] i_hit_slot_in,
    input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] i_hit_rank_in,
    input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] i_lru_slot_in,
    output logic                                      o_hit,
    output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] o_hit_slot,
    output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] o_hit_rank,
    output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] o_lru_slot
);

    localparam int unsigned IW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [lru_lcc_pkg::KEY_W-1:0] r_tag;
    logic                          r_valid;
    logic [IW-1:0]                 r_rank;

    logic match;
    logic is_lru;
    logic is_free;
    logic target;
    logic age;

    // Local compare and selection
    always_comb begin
        match   = r_valid && (r_tag == i_cmd.key);
        is_lru  = r_valid && (r_rank == i_lru_rank);
        is_free = (MY_IDX == i_fill_idx);
        if (i_cmd.hit) begin
            target = match;
        end else if (i_cmd.fill) begin
            target = is_free;
        end else begin
            target = is_lru;
        end
        // On a hit only entries more recent than the touched one age
        age = r_valid && !target && (!i_cmd.hit || (r_rank < i_limit));
    end

    // Hand lookup results down the row
    assign o_hit      = i_hit_in | match;
    assign o_hit_slot = i_hit_slot_in | (match ? MY_IDX : '0);
    assign o_hit_rank = i_hit_rank_in | (match ? r_rank : '0);
    assign o_lru_slot = i_lru_slot_in | (is_lru ? MY_IDX : '0);

    // Valid bit and recency rank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_cmd.clear) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_cmd.update) begin
            if (target) begin
                r_valid <= 1'b1;
                r_rank  <= '0;
            end else if (age) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    // Tag written on fill or replace
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && target && !i_cmd.hit) begin
            r_tag <= i_cmd.key;
        end
    end

endmodule

### sv/lru_lcc_chk.sv
// Port-level timing checks for lru_lookup_cost_counter, bound to the top level.
// Depends on lru_lcc_pkg and lru_lookup_cost_counter_assert.svh.
`include "lru_lookup_cost_counter_assert.svh"

module lru_lcc_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_done,
    input logic [lru_lcc_pkg::TOTAL_W-1:0]    o_total_cost
);

    // A taken request occupies exactly one busy cycle
    `LCC_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)
    `LCC_ASSERT_NEXT(a_done_after_busy, i_clk, i_rst_n, busy, o_done && !busy)
    // Every result strobe belongs to a request
    `LCC_ASSERT_SAME(a_done_has_request, i_clk, i_rst_n, o_done, $past(busy))
    // Total holds unless a request was just taken or just finished
    `LCC_ASSERT_SAME(a_total_stable, i_clk, i_rst_n, !busy && !$past(busy), $stable(o_total_cost))

endmodule

bind lru_lookup_cost_counter lru_lcc_chk u_lru_lcc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_total_cost (o_total_cost)
);
